/* hdl/wel_pkg.sv */
package wel_pkg;

  // Default sizes of the edge store and vertex space.
  localparam int MAX_EDGES_DEF    = 256;
  localparam int MAX_VERTICES_DEF = 256;

  // Field widths fixed by the word formats.
  localparam int VID_W       = 8;
  localparam int WEIGHT_W    = 32;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 9;
  localparam int VTOTAL_W    = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int ENTRY_W     = 2 * VID_W + WEIGHT_W;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_TOTAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IS_DIRECTED  = 2'd1;

  typedef struct packed {
    logic [VID_W-1:0]    src;
    logic [VID_W-1:0]    dst;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic [VID_W-1:0]           src;
    logic [VID_W-1:0]           dst;
    logic signed [WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [VTOTAL_W-1:0] vertex_total;
    logic                is_directed;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

/* hdl/wel_if.sv */
interface wel_req_if import wel_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [VID_W-1:0]           source_vertex;
  logic [VID_W-1:0]           target_vertex;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, action, source_vertex, target_vertex, edge_weight,
                  input ready);
  modport sink (input valid, action, source_vertex, target_vertex, edge_weight,
                output ready);
endinterface

interface wel_rsp_if import wel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  edges_stored;

  modport source (output valid, status, edges_stored, input ready);
  modport sink (input valid, status, edges_stored, output ready);
endinterface

interface wel_cfg_if import wel_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/wel_ram.sv */
module wel_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/wel_engine.sv */
module wel_engine import wel_pkg::*; #(
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_t      req_in,
  input  cfg_t      cfg_in,
  input  logic      rsp_free,
  output eng_stat_t stat,
  output rsp_t      rsp_out
);

  localparam int IDX_W = $clog2(MAX_EDGES);
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MIRROR = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state;
  req_t                cur;
  logic                undirected;
  logic [CNT_W-1:0]    total;
  logic [CNT_W-1:0]    ptr;
  logic                pend;
  logic [CNT_W-1:0]    pend_idx;
  logic                pos_found;
  logic                rev_found;
  logic [CNT_W-1:0]    pos_idx;
  logic [CNT_W-1:0]    rev_idx;
  logic [CNT_W-1:0]    wr_ptr;
  logic [CNT_W-1:0]    mirror_addr;
  logic                mirror_grow;
  logic                del2;
  logic [STATUS_W-1:0] status;

  logic                re;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;
  entry_t              rdata;
  logic                src_ok;
  logic                dst_ok;
  logic                need2;
  logic [CNT_W:0]      need_total;
  logic                table_full;
  logic                rm_del2;
  logic                skip;

  wel_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Vertex range check against the register and the vertex space.
  assign src_ok = ({1'b0, req_in.src} < cfg_in.vertex_total) &&
                  (32'(req_in.src) < MAX_VERTICES);
  assign dst_ok = ({1'b0, req_in.dst} < cfg_in.vertex_total) &&
                  (32'(req_in.dst) < MAX_VERTICES);

  // Room check for appending a new edge and maybe its mirror.
  assign need2      = undirected && (cur.src != cur.dst) && !rev_found;
  assign need_total = {1'b0, total} + (need2 ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
  assign table_full = need_total > (CNT_W+1)'(MAX_EDGES);
  assign rm_del2    = undirected && rev_found && (rev_idx != pos_idx);

  // Reads walk the stored entries one per cycle during a scan or a shift.
  assign re   = ((state == S_SCAN) || (state == S_SHIFT)) && (ptr < total);
  assign skip = (pend_idx == pos_idx) || (del2 && (pend_idx == rev_idx));

  // Write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = total[IDX_W-1:0];
    wdata = '{src: cur.src, dst: cur.dst, weight: cur.weight};
    case (state)
      S_DECIDE: begin
        if (cur.action == ACT_ADD) begin
          if (pos_found) begin
            we    = 1'b1;
            waddr = pos_idx[IDX_W-1:0];
          end else if (!table_full) begin
            we = 1'b1;
          end
        end
      end
      S_MIRROR: begin
        we    = 1'b1;
        waddr = mirror_addr[IDX_W-1:0];
        wdata = '{src: cur.dst, dst: cur.src, weight: cur.weight};
      end
      S_SHIFT: begin
        we    = pend && !skip;
        waddr = wr_ptr[IDX_W-1:0];
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      pend  <= 1'b0;
    end else begin
      pend     <= re;
      pend_idx <= ptr;
      if (re) begin
        ptr <= ptr + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur        <= req_in;
            undirected <= !cfg_in.is_directed;
            pos_found  <= 1'b0;
            rev_found  <= 1'b0;
            ptr        <= '0;
            status     <= ST_OK;
            state      <= S_DONE;
            if ((req_in.action == ACT_ADD) || (req_in.action == ACT_REMOVE)) begin
              if (!src_ok || !dst_ok) begin
                status <= ST_BAD_VERTEX;
              end else begin
                state <= S_SCAN;
              end
            end else if (req_in.action == ACT_CLEAR) begin
              total <= '0;
            end
          end
        end
        S_SCAN: begin
          // Note the first match of the edge and of its reverse.
          if (pend) begin
            if (!pos_found && rdata.src == cur.src && rdata.dst == cur.dst) begin
              pos_found <= 1'b1;
              pos_idx   <= pend_idx;
            end
            if (!rev_found && rdata.src == cur.dst && rdata.dst == cur.src) begin
              rev_found <= 1'b1;
              rev_idx   <= pend_idx;
            end
          end
          if (!re && !pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          if (cur.action == ACT_ADD) begin
            if (pos_found) begin
              status      <= ST_UPDATED;
              mirror_addr <= rev_idx;
              mirror_grow <= 1'b0;
              if (undirected && rev_found && (rev_idx != pos_idx)) begin
                state <= S_MIRROR;
              end
            end else if (table_full) begin
              status <= ST_FULL;
            end else begin
              status      <= ST_OK;
              total       <= total + CNT_W'(1);
              mirror_addr <= total + CNT_W'(1);
              mirror_grow <= 1'b1;
              if (need2) begin
                state <= S_MIRROR;
              end
            end
          end else if (!pos_found) begin
            status <= ST_NOT_FOUND;
          end else begin
            // Compact from the lower of the deleted positions.
            status <= ST_OK;
            del2   <= rm_del2;
            if (rm_del2 && (rev_idx < pos_idx)) begin
              ptr    <= rev_idx;
              wr_ptr <= rev_idx;
            end else begin
              ptr    <= pos_idx;
              wr_ptr <= pos_idx;
            end
            state <= S_SHIFT;
          end
        end
        S_MIRROR: begin
          if (mirror_grow) begin
            total <= total + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SHIFT: begin
          if (pend && !skip) begin
            wr_ptr <= wr_ptr + CNT_W'(1);
          end
          if (!re && !pend) begin
            total <= total - (del2 ? CNT_W'(2) : CNT_W'(1));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.done      = (state == S_DONE) && rsp_free;
  assign rsp_out.status = status;
  assign rsp_out.count  = COUNT_W'(total);

endmodule

/* hdl/weighted_edge_list_table.sv */
// Channel  Dir  Word
// -------  ---  ------------------------------------------------------
// req      in   action, source_vertex, target_vertex, edge_weight
// rsp      out  status, edges_stored
// cfg      in   index, data (0 vertex_total, 1 is_directed)
//
// Add and remove requests with valid vertices walk the stored edges through the
// store's single read port, one per cycle. An add then writes the entry and, when
// needed, its mirror; a remove shifts later entries down. Others skip the scan.
// Reset empties the table at once through the edge count; no sweep is needed.
// The response register holds one word; a request is taken while it waits, and
// the next result waits in the engine until that word is taken.
module weighted_edge_list_table import wel_pkg::*; #(
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  wel_req_if.sink   req,
  wel_rsp_if.source rsp,
  wel_cfg_if.sink   cfg
);

  logic [VTOTAL_W-1:0] vertex_total;
  logic                is_directed;
  logic                rsp_valid;
  rsp_t                rsp_word;
  logic                rsp_free;
  eng_stat_t           eng_stat;
  rsp_t                eng_rsp;
  req_t                req_word;
  cfg_t                cfg_word;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_total <= VTOTAL_W'(256);
      is_directed  <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_VERTEX_TOTAL: vertex_total <= cfg.data[VTOTAL_W-1:0];
        CFG_IS_DIRECTED:  is_directed  <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_word = '{vertex_total: vertex_total, is_directed: is_directed};
  assign req_word = '{action: req.action, src: req.source_vertex,
                      dst: req.target_vertex, weight: req.edge_weight};
  assign req.ready = eng_stat.idle;
  assign rsp_free  = !rsp_valid || rsp.ready;

  wel_engine #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid && eng_stat.idle),
    .req_in   (req_word),
    .cfg_in   (cfg_word),
    .rsp_free (rsp_free),
    .stat     (eng_stat),
    .rsp_out  (eng_rsp)
  );

  // Response output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_stat.done) begin
      rsp_valid <= 1'b1;
      rsp_word  <= eng_rsp;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_word.status;
  assign rsp.edges_stored = rsp_word.count;

  // A finished result is only handed over when the output register is free.
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    eng_stat.done |-> (!rsp_valid || rsp.ready))
    else $error("result handed over while output register was busy");

  // An accepted request keeps the engine busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !eng_stat.idle)
    else $error("engine idle right after accepting a request");

  // A completed request always yields a response word in the next cycle.
  a_done_to_rsp: assert property (@(posedge clk) disable iff (rst)
    eng_stat.done |=> rsp_valid)
    else $error("completed request produced no response word");

endmodule
